// ----- src/dwg_pkg.sv -----
// Shared types, constants and micro-operation sequencing for the DAC waveform generator.
package dwg_pkg;

    localparam int CFG_IW  = 8;
    localparam int DATA_W  = 16;
    localparam int CODE_W  = 12;
    localparam int IDX_W   = 10;

    localparam logic [CFG_IW-1:0] CFG_SHAPE = 8'd0;
    localparam logic [CFG_IW-1:0] CFG_FREQ  = 8'd1;

    localparam logic [31:0] CLK_HZ     = 32'd72000000;
    localparam logic [31:0] FS_MAX     = 32'd500000;
    localparam logic [31:0] N_NUMER    = 32'd1000000;
    localparam logic [31:0] ONE_Q30    = 32'h4000_0000;
    localparam logic [31:0] PI_Q30     = 32'hC90F_DAA2;
    localparam logic [31:0] CODE_GAIN  = 32'd40950;
    localparam logic [31:0] CODE_BIAS  = 32'd540672;
    localparam logic [31:0] CODE_DIV   = 32'd1081344;
    localparam logic [31:0] TRI_GAIN   = 32'd163800;
    localparam logic [16:0] AMP_FULL   = 17'd32768;
    localparam logic [CODE_W-1:0] CODE_MID  = 12'd1241;
    localparam logic [CODE_W-1:0] CODE_HIGH = 12'd2482;
    localparam logic [1:0]  SHAPE_RST  = 2'd0;
    localparam logic [15:0] FREQ_RST   = 16'd1000;
    localparam logic [15:0] RELOAD_RST = 16'd71;

    typedef enum logic [1:0] {
        SH_OFF    = 2'd0,
        SH_SINE   = 2'd1,
        SH_TRI    = 2'd2,
        SH_SQUARE = 2'd3
    } t_shape;

    // Micro-operations run by the shared multiplier and divider.
    typedef enum logic [4:0] {
        U_NONE, U_RATE, U_DIV_R, U_DIV_N,
        U_PH, U_X, U_X2, U_T72, U_XTA, U_T42, U_XTB, U_T20, U_XTC, U_T6,
        U_S, U_U, U_CODE, U_TRI_M, U_TRI_D
    } t_uop;

    typedef struct packed {
        logic idle;
        logic mul_en;
        logic div_start;
        logic wb;
        logic out_load;
        t_uop uop;
    } t_cmd;

    typedef struct packed {
        logic   cfg_start;
        logic   point_start;
        t_shape shape;
        logic   div_done;
    } t_stat;

    function automatic t_uop uop_next(input t_uop u);
        t_uop nx;
        unique case (u)
            U_RATE:  nx = U_DIV_R;
            U_DIV_R: nx = U_DIV_N;
            U_PH:    nx = U_X;
            U_X:     nx = U_X2;
            U_X2:    nx = U_T72;
            U_T72:   nx = U_XTA;
            U_XTA:   nx = U_T42;
            U_T42:   nx = U_XTB;
            U_XTB:   nx = U_T20;
            U_T20:   nx = U_XTC;
            U_XTC:   nx = U_T6;
            U_T6:    nx = U_S;
            U_S:     nx = U_U;
            U_U:     nx = U_CODE;
            U_TRI_M: nx = U_TRI_D;
            default: nx = U_NONE;
        endcase
        return nx;
    endfunction

    function automatic logic uop_is_div(input t_uop u);
        logic d;
        case (u)
            U_DIV_R, U_DIV_N, U_PH, U_T72, U_T42, U_T20, U_T6, U_CODE, U_TRI_D: d = 1'b1;
            default: d = 1'b0;
        endcase
        return d;
    endfunction

endpackage

// ----- src/dac_waveform_generator.sv -----
// Top level of the table-driven DAC waveform generator.
//
// Each input word carries one 72 MHz timer tick (tick = 1) or nothing (tick = 0).
// Every reload + 1 ticks the block produces one output word: the 12-bit DAC code
// of the next point, its index within the period and a flag on the last point.
// A configuration write to shape or frequency_hz restarts the waveform at point 0
// and recomputes the points per period and the tick reload. That takes one
// multiply and two passes through the shared divider, during which the input
// channel stalls. Configuration is accepted only while the controller is idle.
// From the accepted tick to a valid output word, off and square need no arithmetic,
// triangle needs one multiply and one divide, and sine seven multiplies and six
// divides, all on the shared multiplier and the shared 2-bit-per-cycle divider.
// The input is stalled while a point is being computed. Ticks that produce no point
// are still accepted while an output word waits; a tick that would produce a point
// stalls until the waiting word has been taken by the receiver.
// Reset restores shape off, 1000 Hz, POINTS_MAX points and a reload of 71 without
// recomputing them; the output register is emptied.
module dac_waveform_generator #(
    parameter int POINTS_MAX = 1000
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_in_tick,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [dwg_pkg::CODE_W-1:0] o_dac_code,
    output logic [dwg_pkg::IDX_W-1:0]  o_point_index,
    output logic                       o_period_end,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [dwg_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [dwg_pkg::DATA_W-1:0] i_cfg_data
);
    import dwg_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Sequencer for the restart and point computations.
    dwg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Counters, configuration, arithmetic units and the output register.
    dwg_dp #(
        .POINTS_MAX (POINTS_MAX)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_tick     (i_in_tick),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_dac_code    (o_dac_code),
        .o_point_index (o_point_index),
        .o_period_end  (o_period_end),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (cmd),
        .o_stat        (stat)
    );
endmodule

// ----- src/dwg_div.sv -----
// Unsigned 32-bit restoring divider retiring two quotient bits per cycle.
module dwg_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic [31:0] o_quo,
    output logic        o_done
);
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_quo, n_quo;
    logic [31:0] r_den;
    logic [3:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] sh;

    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        sh    = '0;
        for (int j = 0; j < 2; j++) begin
            sh    = {n_rem, n_quo[31]};
            n_quo = {n_quo[30:0], 1'b0};
            if (sh >= {1'b0, r_den}) begin
                sh       = sh - {1'b0, r_den};
                n_quo[0] = 1'b1;
            end
            n_rem = sh[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_num;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;
endmodule

// ----- src/dwg_dp.sv -----
// Datapath: registers, tick counting, shared multiplier and divider, output word register.
module dwg_dp #(
    parameter int POINTS_MAX = 1000
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_in_tick,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [dwg_pkg::CODE_W-1:0] o_dac_code,
    output logic [dwg_pkg::IDX_W-1:0]  o_point_index,
    output logic                      o_period_end,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [dwg_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [dwg_pkg::DATA_W-1:0] i_cfg_data,
    input  dwg_pkg::t_cmd             i_cmd,
    output dwg_pkg::t_stat            o_stat
);
    import dwg_pkg::*;

    localparam int NW = $clog2(POINTS_MAX + 1);
    localparam logic [NW-1:0] N_MAX = NW'(POINTS_MAX);

    logic [1:0]        r_shape;
    logic [15:0]       r_freq;
    logic [15:0]       r_count;
    logic [15:0]       r_reload;
    logic [NW-1:0]     r_n, r_pc, r_i;
    logic              r_last;
    logic [31:0]       r_rate, r_x, r_x2, r_t, r_m;
    logic [11:0]       r_phase;
    logic [16:0]       r_amp;
    logic [CODE_W-1:0] r_code;
    logic [63:0]       r_prod;
    logic              r_o_valid;
    logic [CODE_W-1:0] r_o_code;
    logic [IDX_W-1:0]  r_o_index;
    logic              r_o_end;

    logic          at_reload, in_acc, emit, cfg_wr, cfg_hit;
    logic [NW-1:0] i_new, h_new, h_cur, tri_num;
    logic [31:0]   n32, mul_a, mul_b, div_num, div_den, quo, qm1;
    logic          div_done;
    logic [10:0]   k;
    logic [16:0]   u;
    logic [32:0]   s_rnd;
    logic [17:0]   a18;

    assign at_reload   = (r_count >= r_reload);
    assign o_in_stall  = !i_cmd.idle || i_cfg_valid || (r_o_valid && at_reload);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign emit        = in_acc && i_in_tick && at_reload;
    assign o_cfg_ready = i_cmd.idle;
    assign cfg_wr      = i_cfg_valid && i_cmd.idle;
    assign cfg_hit     = cfg_wr && ((i_cfg_index == CFG_SHAPE) || (i_cfg_index == CFG_FREQ));

    assign i_new   = (r_pc >= r_n) ? '0 : r_pc;
    assign h_new   = r_n >> 1;
    assign h_cur   = r_n >> 1;
    assign tri_num = (r_i < h_cur) ? r_i : (r_n - r_i);
    assign n32     = 32'(r_n);
    assign k       = r_phase[10] ? (11'd1024 - {1'b0, r_phase[9:0]}) : {1'b0, r_phase[9:0]};
    assign u       = r_phase[11] ? (AMP_FULL - r_amp) : (AMP_FULL + r_amp);
    assign s_rnd   = {1'b0, r_prod[61:30]} + 33'h0000_4000;
    assign a18     = s_rnd[32:15];
    assign qm1     = quo - 32'd1;

    // Operand selection for the shared units.
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        div_num = '0;
        div_den = 32'd1;
        case (i_cmd.uop)
            U_RATE:  begin mul_a = 32'(POINTS_MAX); mul_b = 32'(r_freq); end
            U_DIV_R: begin
                div_num = CLK_HZ;
                div_den = (r_rate > FS_MAX) ? FS_MAX : r_rate;
            end
            U_DIV_N: begin
                div_num = N_NUMER + 32'(r_freq);
                div_den = {15'd0, r_freq, 1'b0};
            end
            U_PH:    begin div_num = (n32 << 13) - (n32 << 13) + (32'(r_i) << 13) + n32;
                           div_den = n32 << 1; end
            U_X:     begin mul_a = 32'(k); mul_b = PI_Q30; end
            U_X2:    begin mul_a = r_x; mul_b = r_x; end
            U_T72:   begin div_num = r_x2; div_den = 32'd72; end
            U_XTA, U_XTB, U_XTC: begin mul_a = r_x2; mul_b = r_t; end
            U_T42:   begin div_num = r_m; div_den = 32'd42; end
            U_T20:   begin div_num = r_m; div_den = 32'd20; end
            U_T6:    begin div_num = r_m; div_den = 32'd6; end
            U_S:     begin mul_a = r_x; mul_b = r_t; end
            U_U:     begin mul_a = 32'(u); mul_b = CODE_GAIN; end
            U_CODE:  begin div_num = r_m; div_den = CODE_DIV; end
            U_TRI_M: begin mul_a = 32'(tri_num); mul_b = TRI_GAIN; end
            U_TRI_D: begin div_num = r_m; div_den = (n32 << 6) + (n32 << 1); end
            default: ;
        endcase
    end

    dwg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_quo   (quo),
        .o_done  (div_done)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= mul_a * mul_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shape   <= SHAPE_RST;
            r_freq    <= FREQ_RST;
            r_count   <= '0;
            r_reload  <= RELOAD_RST;
            r_n       <= N_MAX;
            r_pc      <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && !i_out_stall) begin
                r_o_valid <= 1'b0;
            end
            if (cfg_hit) begin
                if (i_cfg_index == CFG_SHAPE) begin
                    r_shape <= i_cfg_data[1:0];
                end else begin
                    r_freq <= i_cfg_data;
                end
                r_count <= '0;
                r_pc    <= '0;
            end
            if (in_acc && i_in_tick) begin
                if (at_reload) begin
                    r_count <= '0;
                    r_pc    <= ((i_new + 1'b1) >= r_n) ? '0 : (i_new + 1'b1);
                end else begin
                    r_count <= r_count + 16'd1;
                end
            end
            if (i_cmd.wb) begin
                case (i_cmd.uop)
                    U_DIV_R: begin
                        if (r_freq == 16'd0) begin
                            r_reload <= 16'hFFFF;
                        end else if (quo == 32'd0) begin
                            r_reload <= '0;
                        end else if (qm1 > 32'd65535) begin
                            r_reload <= 16'hFFFF;
                        end else begin
                            r_reload <= qm1[15:0];
                        end
                    end
                    U_DIV_N: begin
                        if (r_rate <= FS_MAX) begin
                            r_n <= N_MAX;
                        end else if (quo == 32'd0) begin
                            r_n <= NW'(1);
                        end else if (quo > 32'(POINTS_MAX)) begin
                            r_n <= N_MAX;
                        end else begin
                            r_n <= quo[NW-1:0];
                        end
                    end
                    default: ;
                endcase
            end
            if (i_cmd.out_load) begin
                r_o_valid <= 1'b1;
            end
        end
    end

    // Payload registers without reset.
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_i    <= i_new;
            r_last <= ((i_new + 1'b1) == r_n);
            if ((t_shape'(r_shape) == SH_SQUARE) && (i_new < h_new)) begin
                r_code <= CODE_HIGH;
            end else begin
                r_code <= CODE_MID;
            end
        end
        if (i_cmd.wb) begin
            case (i_cmd.uop)
                U_RATE:  r_rate  <= r_prod[31:0];
                U_PH:    r_phase <= quo[11:0];
                U_X:     r_x     <= r_prod[42:11];
                U_X2:    r_x2    <= r_prod[61:30];
                U_T72, U_T42, U_T20, U_T6: r_t <= ONE_Q30 - quo;
                U_XTA, U_XTB, U_XTC:       r_m <= r_prod[61:30];
                U_S:     r_amp   <= (a18 > 18'(AMP_FULL)) ? AMP_FULL : a18[16:0];
                U_U:     r_m     <= r_prod[31:0] + CODE_BIAS;
                U_TRI_M: r_m     <= {r_prod[30:0], 1'b0} + (n32 << 5) + n32;
                U_CODE, U_TRI_D: r_code <= quo[CODE_W-1:0];
                default: ;
            endcase
        end
        if (i_cmd.out_load) begin
            r_o_code  <= r_code;
            r_o_index <= IDX_W'(r_i);
            r_o_end   <= r_last;
        end
    end

    assign o_stat.cfg_start   = cfg_hit;
    assign o_stat.point_start = emit;
    assign o_stat.shape       = t_shape'(r_shape);
    assign o_stat.div_done    = div_done;

    assign o_out_valid   = r_o_valid;
    assign o_dac_code    = r_o_code;
    assign o_point_index = r_o_index;
    assign o_period_end  = r_o_end;
endmodule

// ----- src/dwg_ctrl.sv -----
// Controller: steps the micro-operation sequences for restart and for each point.
module dwg_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  dwg_pkg::t_stat i_stat,
    output dwg_pkg::t_cmd  o_cmd
);
    import dwg_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ISSUE = 5'b00010,
        S_MWB   = 5'b00100,
        S_DIV   = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    t_uop   r_uop, n_uop;
    logic   r_pt, n_pt;
    t_uop   nxt;

    assign nxt = uop_next(r_uop);

    always_comb begin
        n_state         = r_state;
        n_uop           = r_uop;
        n_pt            = r_pt;
        o_cmd.idle      = 1'b0;
        o_cmd.mul_en    = 1'b0;
        o_cmd.div_start = 1'b0;
        o_cmd.wb        = 1'b0;
        o_cmd.out_load  = 1'b0;
        o_cmd.uop       = r_uop;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.idle = 1'b1;
                if (i_stat.cfg_start) begin
                    n_pt    = 1'b0;
                    n_uop   = U_RATE;
                    n_state = S_ISSUE;
                end else if (i_stat.point_start) begin
                    n_pt = 1'b1;
                    if (i_stat.shape == SH_SINE) begin
                        n_uop   = U_PH;
                        n_state = S_ISSUE;
                    end else if (i_stat.shape == SH_TRI) begin
                        n_uop   = U_TRI_M;
                        n_state = S_ISSUE;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_ISSUE: begin
                if (uop_is_div(r_uop)) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    o_cmd.mul_en = 1'b1;
                    n_state      = S_MWB;
                end
            end
            S_MWB, S_DIV: begin
                if ((r_state == S_MWB) || i_stat.div_done) begin
                    o_cmd.wb = 1'b1;
                    n_uop    = nxt;
                    if (nxt != U_NONE) begin
                        n_state = S_ISSUE;
                    end else begin
                        n_state = r_pt ? S_DONE : S_IDLE;
                    end
                end
            end
            S_DONE: begin
                o_cmd.out_load = 1'b1;
                n_state        = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_uop   <= U_NONE;
            r_pt    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_uop   <= n_uop;
            r_pt    <= n_pt;
        end
    end
endmodule
